### hw/rtl/dtp_pkg.sv
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared types, constants and the field-close function of the duration
// text parser.
// ----------------------------------------------------------------------------
package dtp_pkg;

   localparam int MAX_FIELD_DIGITS = 9;
   localparam int MAX_FIELDS       = 3;
   localparam int FRACTION_DIGITS  = 7;

   localparam int SYMBOL_W = 16;
   localparam int DUR_W    = 63;

   localparam longint unsigned FIELD_RANGE = 64'd10 ** MAX_FIELD_DIGITS;
   localparam longint unsigned UNITS       = 64'd10 ** FRACTION_DIGITS;

   localparam int FV_W      = $clog2(FIELD_RANGE);
   localparam int FDC_W     = $clog2(MAX_FIELD_DIGITS + 2);
   localparam int FC_W      = $clog2(MAX_FIELDS + 1);
   localparam int SEC_W     = FV_W + 6 * (MAX_FIELDS - 1);
   localparam int FRAC_W    = $clog2(UNITS);
   localparam int FP_W      = $clog2(FRACTION_DIGITS + 1);
   localparam int FW_IDX_W  = (FRACTION_DIGITS > 1) ? $clog2(FRACTION_DIGITS) : 1;
   localparam int UNITS_W   = $clog2(UNITS + 1);
   localparam int SEC_LO_W  = SEC_W / 2;
   localparam int SEC_HI_W  = SEC_W - SEC_LO_W;
   localparam int PROD_LO_W = SEC_LO_W + UNITS_W;
   localparam int PROD_HI_W = SEC_HI_W + UNITS_W;
   localparam int TOTAL_W   = SEC_W + UNITS_W + 1;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [SYMBOL_W-1:0] CHAR_ZERO  = 16'h0030;
   localparam logic [SYMBOL_W-1:0] CHAR_NINE  = 16'h0039;
   localparam logic [SYMBOL_W-1:0] CHAR_COLON = 16'h003A;
   localparam logic [SYMBOL_W-1:0] CHAR_DOT   = 16'h002E;

   localparam logic [UNITS_W-1:0] UNITS_VALUE = UNITS_W'(UNITS);

   typedef logic [FRAC_W-1:0] frac_weight_table_type [FRACTION_DIGITS];

   function automatic frac_weight_table_type make_frac_weights();
      frac_weight_table_type t;
      longint unsigned w;
      w = 1;
      for (int i = FRACTION_DIGITS - 1; i >= 0; i--) begin
         t[i] = FRAC_W'(w);
         w = w * 10;
      end
      return t;
   endfunction

   localparam frac_weight_table_type FRAC_WEIGHT = make_frac_weights();

   typedef enum logic [2:0] {
      CLS_NONE,
      CLS_DIGIT,
      CLS_COLON,
      CLS_DOT,
      CLS_OTHER
   } char_class_type;

   typedef struct packed {
      char_class_type cls;
      logic [3:0]     digit;
      logic           last;
   } char_item_type;

   typedef struct packed {
      logic [FV_W-1:0]   field_value;
      logic [FDC_W-1:0]  digit_count;
      logic [FC_W-1:0]   field_count;
      logic [SEC_W-1:0]  seconds;
      logic              in_fraction;
      logic [FRAC_W-1:0] frac_sum;
      logic [FP_W-1:0]   frac_pos;
      logic              failed;
   } parse_state_type;

   // ends a colon-separated field and folds it into the seconds total
   function automatic parse_state_type close_field(input parse_state_type s);
      parse_state_type r;
      r = s;
      if (s.digit_count == '0 || s.digit_count > FDC_W'(MAX_FIELD_DIGITS)) begin
         r.failed = 1'b1;
      end
      if (s.field_count == FC_W'(MAX_FIELDS)) begin
         r.failed = 1'b1;
      end else begin
         r.field_count = s.field_count + 1'b1;
      end
      if (!r.failed) begin
         r.seconds = (s.seconds << 6) - (s.seconds << 2) + SEC_W'(s.field_value);
      end
      r.field_value = '0;
      r.digit_count = '0;
      return r;
   endfunction

endpackage

### hw/rtl/dtp_front.sv
// ----------------------------------------------------------------------------
// dtp_front
// Takes characters from the request channel and classifies them into
// digit, colon, dot, other or no character for the queue.
// ----------------------------------------------------------------------------
module dtp_front import dtp_pkg::*; (
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SYMBOL_W-1:0] req_symbol,
   input  logic                req_has_symbol,
   input  logic                req_last,
   output logic                q_valid,
   input  logic                q_ready,
   output char_item_type       q_item
);

   logic is_digit;

   assign is_digit  = (req_symbol >= CHAR_ZERO) && (req_symbol <= CHAR_NINE);
   assign q_valid   = req_valid;
   assign req_ready = q_ready;

   always_comb begin
      q_item.last  = req_last;
      q_item.digit = is_digit ? req_symbol[3:0] : 4'd0;
      if (!req_has_symbol) begin
         q_item.cls = CLS_NONE;
      end else if (is_digit) begin
         q_item.cls = CLS_DIGIT;
      end else if (req_symbol == CHAR_COLON) begin
         q_item.cls = CLS_COLON;
      end else if (req_symbol == CHAR_DOT) begin
         q_item.cls = CLS_DOT;
      end else begin
         q_item.cls = CLS_OTHER;
      end
   end

endmodule

### hw/rtl/dtp_queue.sv
// ----------------------------------------------------------------------------
// dtp_queue
// Short queue of classified characters between the front and back parts.
// ----------------------------------------------------------------------------
module dtp_queue import dtp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  char_item_type in_item,
   output logic          out_valid,
   input  logic          out_ready,
   output char_item_type out_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   char_item_type    entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

### hw/rtl/dtp_back.sv
// ----------------------------------------------------------------------------
// dtp_back
// Parser state: accumulates field digits, closes fields on colon and dot,
// sums fraction digits, and hands the state on at the end of a string.
// ----------------------------------------------------------------------------
module dtp_back import dtp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   output logic            q_ready,
   input  char_item_type   q_item,
   output logic            fin_valid,
   input  logic            fin_ready,
   output parse_state_type fin_state
);

   parse_state_type  state_ff, state_in;
   parse_state_type  step;
   logic [FRAC_W-1:0] frac_term;
   logic              pop;

   assign q_ready   = !q_item.last || fin_ready;
   assign pop       = q_valid && q_ready;
   assign fin_valid = q_valid && q_item.last;
   assign fin_state = step;

   assign frac_term = FRAC_W'({{(FRAC_W - 4){1'b0}}, q_item.digit}
                      * FRAC_WEIGHT[state_ff.frac_pos[FW_IDX_W-1:0]]);

   always_comb begin
      step = state_ff;
      if (q_item.cls != CLS_NONE && !state_ff.failed) begin
         if (state_ff.in_fraction) begin
            if (q_item.cls != CLS_DIGIT) begin
               step.failed = 1'b1;
            end else if (state_ff.frac_pos < FP_W'(FRACTION_DIGITS)) begin
               step.frac_sum = state_ff.frac_sum + frac_term;
               step.frac_pos = state_ff.frac_pos + 1'b1;
            end
         end else begin
            unique case (q_item.cls)
               CLS_DIGIT: begin
                  if (state_ff.digit_count < FDC_W'(MAX_FIELD_DIGITS)) begin
                     step.field_value = (state_ff.field_value << 3)
                                        + (state_ff.field_value << 1)
                                        + FV_W'(q_item.digit);
                     step.digit_count = state_ff.digit_count + 1'b1;
                  end else begin
                     step.digit_count = FDC_W'(MAX_FIELD_DIGITS + 1);
                     step.failed      = 1'b1;
                  end
               end
               CLS_COLON: begin
                  step = close_field(state_ff);
               end
               CLS_DOT: begin
                  step             = close_field(state_ff);
                  step.in_fraction = 1'b1;
               end
               default: begin
                  step.failed = 1'b1;
               end
            endcase
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      if (pop) begin
         state_in = q_item.last ? '0 : step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/dtp_finish.sv
// ----------------------------------------------------------------------------
// dtp_finish
// End-of-string pipeline: closes the last field, scales seconds to 100 ns
// units in two partial products, checks the 63-bit range and holds the
// result for the response channel.
// ----------------------------------------------------------------------------
module dtp_finish import dtp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             fin_valid,
   output logic             fin_ready,
   input  parse_state_type  fin_state,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_valid_res,
   output logic [DUR_W-1:0] rsp_duration
);

   logic              a_valid_ff, a_valid_in;
   parse_state_type   a_state_ff;
   logic              b_valid_ff, b_valid_in;
   logic              b_ok_ff;
   logic [SEC_W-1:0]  b_sec_ff;
   logic [FRAC_W-1:0] b_frac_ff;
   logic              c_valid_ff, c_valid_in;
   logic              c_ok_ff;
   logic [PROD_LO_W-1:0] c_lo_ff;
   logic [PROD_HI_W-1:0] c_hi_ff;
   logic [FRAC_W-1:0] c_frac_ff;
   logic              out_valid_ff, out_valid_in;
   logic              out_ok_ff;
   logic [DUR_W-1:0]  out_dur_ff;

   logic              out_free, c_free, b_free, a_free;
   parse_state_type   closed;
   logic [TOTAL_W-1:0] total;
   logic              fits;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign c_free    = !c_valid_ff || out_free;
   assign b_free    = !b_valid_ff || c_free;
   assign a_free    = !a_valid_ff || b_free;
   assign fin_ready = a_free;

   assign a_valid_in   = a_free ? fin_valid : a_valid_ff;
   assign b_valid_in   = b_free ? a_valid_ff : b_valid_ff;
   assign c_valid_in   = c_free ? b_valid_ff : c_valid_ff;
   assign out_valid_in = out_free ? c_valid_ff : out_valid_ff;

   assign closed = (a_state_ff.failed || a_state_ff.in_fraction) ?
                   a_state_ff : close_field(a_state_ff);

   assign total = (TOTAL_W'(c_hi_ff) << SEC_LO_W) + TOTAL_W'(c_lo_ff)
                  + TOTAL_W'(c_frac_ff);
   assign fits  = (total[TOTAL_W-1:DUR_W] == '0);

   assign rsp_valid     = out_valid_ff;
   assign rsp_valid_res = out_ok_ff;
   assign rsp_duration  = out_dur_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= c_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_free && fin_valid) begin
         a_state_ff <= fin_state;
      end
      if (b_free && a_valid_ff) begin
         b_ok_ff   <= !closed.failed;
         b_sec_ff  <= closed.seconds;
         b_frac_ff <= closed.frac_sum;
      end
      if (c_free && b_valid_ff) begin
         c_ok_ff   <= b_ok_ff;
         c_lo_ff   <= PROD_LO_W'(b_sec_ff[SEC_LO_W-1:0]) * PROD_LO_W'(UNITS_VALUE);
         c_hi_ff   <= PROD_HI_W'(b_sec_ff[SEC_W-1:SEC_LO_W]) * PROD_HI_W'(UNITS_VALUE);
         c_frac_ff <= b_frac_ff;
      end
      if (out_free && c_valid_ff) begin
         out_ok_ff  <= c_ok_ff && fits;
         out_dur_ff <= (c_ok_ff && fits) ? total[DUR_W-1:0] : '0;
      end
   end

endmodule

### hw/rtl/duration_text_parser.sv
// ----------------------------------------------------------------------------
// duration_text_parser
// Parses [[h:]m:]s[.fraction] text, one character per transfer, into a
// validity flag and a duration in 100 ns units.
// Throughput: one character per cycle while the result path does not stall
// the last item, set by the parser state update in the back part.
// Result path: the queue entry, then the finish registers a, b, c and out.
// Reset: synchronous, clears the queue, parser state and result pipeline.
// ----------------------------------------------------------------------------
module duration_text_parser import dtp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SYMBOL_W-1:0] req_symbol,
   input  logic                req_has_symbol,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_valid_res,
   output logic [DUR_W-1:0]    rsp_duration
);

   logic            fq_valid, fq_ready;
   char_item_type   fq_item;
   logic            qb_valid, qb_ready;
   char_item_type   qb_item;
   logic            fin_valid, fin_ready;
   parse_state_type fin_state;

   dtp_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_symbol     (req_symbol),
      .req_has_symbol (req_has_symbol),
      .req_last       (req_last),
      .q_valid        (fq_valid),
      .q_ready        (fq_ready),
      .q_item         (fq_item)
   );

   dtp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_item   (fq_item),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_item  (qb_item)
   );

   dtp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (qb_valid),
      .q_ready   (qb_ready),
      .q_item    (qb_item),
      .fin_valid (fin_valid),
      .fin_ready (fin_ready),
      .fin_state (fin_state)
   );

   dtp_finish u_finish (
      .clock         (clock),
      .reset         (reset),
      .fin_valid     (fin_valid),
      .fin_ready     (fin_ready),
      .fin_state     (fin_state),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_valid_res (rsp_valid_res),
      .rsp_duration  (rsp_duration)
   );

endmodule
